// ===== hw/rtl/bwt_backward_search_unit_assert.svh =====
// Assertion macros for the backward search RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BWT_BACKWARD_SEARCH_UNIT_ASSERT_SVH
`define BWT_BACKWARD_SEARCH_UNIT_ASSERT_SVH
// Check an implication on every clock, off during reset.
`define BSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsu check failed");
// Check an implication in the next cycle.
`define BSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsu check failed");
`endif

// ===== hw/rtl/bwt_pkg.sv =====
// Shared types and constants for the backward search unit.
// No dependencies.
package bwt_pkg;
  localparam int unsigned MaxLenDef   = 65536;
  localparam int unsigned AlphabetDef = 256;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0, KIND_FINISH = 2'd1, KIND_PATTERN = 2'd2, KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_LOAD = 2'd0, RES_QUERY = 2'd1, RES_READ = 2'd2
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;     // store one load word
    logic latch_in;    // capture the input word
    logic pfx_clear;   // restart prefix sum
    logic pfx_step;    // one prefix-sum entry
    logic first_set;   // set interval from offsets
    logic scan_init;   // prepare narrowing
    logic scan_lo;     // issue low-side read
    logic scan_hi;     // issue high-side read
    logic narrow_done; // commit new interval
    logic mark_empty;
    logic query_set;
    logic query_clr;
    logic rd_issue;
    logic out_query;
    logic out_read;
    logic out_load;
  } bwt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pfx_last;
    logic query_active;
    logic intv_empty;
    logic scan_skip;  // narrowing is empty up front
    logic lo_hit;
    logic lo_end;
    logic hi_hit;
    logic clr_busy;   // count and offset tables still clearing
  } bwt_sts_t;
endpackage

// ===== hw/rtl/bwt_datapath.sv =====
// Datapath: BWT, rank and suffix memories, counts, offsets and interval.
// Depends on bwt_pkg.
module bwt_datapath import bwt_pkg::*; #(
  parameter int unsigned MAX_LEN  = MaxLenDef,
  parameter int unsigned ALPHABET = AlphabetDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bwt_cmd_t    cmd,
  output bwt_sts_t    sts,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_sa_value,
  input  logic [15:0] in_read_index,
  output logic [1:0]  res_kind,
  output logic        res_found,
  output logic [16:0] res_count,
  output logic [15:0] res_first,
  output logic [15:0] res_last,
  output logic [15:0] res_pos
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = AW + 1;
  localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic [7:0]  bwt_mem [MAX_LEN];
  logic [15:0] sa_mem  [MAX_LEN];
  logic [16:0] rank_mem[MAX_LEN];
  logic [16:0] cnt_mem [ALPHABET];
  logic [16:0] off_mem [ALPHABET];

  logic [LW-1:0] len_r;
  logic [16:0] lo_r, hi_r;
  logic        empty_r, active_r;
  logic [7:0]  sym_r;
  logic [15:0] ridx_r;
  logic [15:0] sav_r;
  logic [SW-1:0] pidx_r;
  logic [16:0] psum_r;
  logic [16:0] lo_ptr_r, hi_ptr_r, scan_lo_b_r, scan_hi_b_r;
  logic [7:0]  rd_bwt_r;
  logic [16:0] rd_rank_r;
  logic [15:0] rd_sa_r;
  logic        rd_v_r;
  logic [16:0] nlo_r;
  logic [16:0] cnt_rd_r, off_rd_r;
  logic        clr_r;
  logic [SW-1:0] clr_idx_r;

  logic sym_ok;
  logic [SW-1:0] sidx;
  assign sym_ok = {24'd0, sym_r} < ALPHABET;
  assign sidx   = sym_r[SW-1:0];

  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_addr = lo_ptr_r[AW-1:0];
    if (cmd.scan_hi) rd_addr = hi_ptr_r[AW-1:0];
  end

  // table address: prefix walk reads one entry ahead, new words read their symbol
  logic [SW-1:0] tab_addr;
  always_comb begin
    priority if (cmd.pfx_clear) tab_addr = '0;
    else if (cmd.pfx_step)      tab_addr = pidx_r + SW'(1);
    else if (cmd.latch_in)      tab_addr = in_symbol[SW-1:0];
    else                        tab_addr = sidx;
  end

  logic load_ok;
  assign load_ok = ({{(32-LW){1'b0}}, len_r} < MAX_LEN) && sym_ok;

  // memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      bwt_mem[len_r[AW-1:0]]  <= sym_r;
      sa_mem[len_r[AW-1:0]]   <= sav_r;
      rank_mem[len_r[AW-1:0]] <= cnt_rd_r;
    end
    rd_bwt_r  <= bwt_mem[rd_addr];
    rd_rank_r <= rank_mem[rd_addr];
    rd_sa_r   <= sa_mem[ridx_r[AW-1:0]];
  end

  // count and offset tables: cleared after reset, one registered read
  always_ff @(posedge clk) begin
    if (clr_r) begin
      cnt_mem[clr_idx_r] <= '0;
      off_mem[clr_idx_r] <= '0;
    end else begin
      if (cmd.load_wr && load_ok) cnt_mem[sidx] <= cnt_rd_r + 17'd1;
      if (cmd.pfx_step) off_mem[pidx_r] <= psum_r;
    end
    cnt_rd_r <= cnt_mem[tab_addr];
    off_rd_r <= off_mem[tab_addr];
  end

  logic [16:0] first_hi;
  assign first_hi = off_rd_r + cnt_rd_r - 17'd1;
  logic [16:0] hi_clip;
  assign hi_clip = ({{(17-LW+1){1'b0}}, hi_r} >= {{(17-LW+1){1'b0}}, 17'(len_r)})
                   ? 17'(len_r) - 17'd1 : hi_r;
  logic [16:0] cand;
  assign cand = off_rd_r + rd_rank_r;
  logic hit;
  assign hit = rd_v_r && (rd_bwt_r == sym_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; lo_r <= '0; hi_r <= '0; empty_r <= 1'b0; active_r <= 1'b0;
      rd_v_r <= 1'b0;
      clr_r <= 1'b1; clr_idx_r <= '0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + SW'(1);
        if ({{(32-SW){1'b0}}, clr_idx_r} == ALPHABET - 1) clr_r <= 1'b0;
      end
      rd_v_r <= cmd.scan_lo || cmd.scan_hi;
      if (cmd.latch_in) begin
        sym_r <= in_symbol;
        ridx_r <= in_read_index;
        sav_r <= in_sa_value;
      end
      if (cmd.load_wr && load_ok) len_r <= len_r + LW'(1);
      if (cmd.pfx_clear) begin
        pidx_r <= '0; psum_r <= '0;
      end
      if (cmd.pfx_step) begin
        psum_r <= psum_r + cnt_rd_r;
        pidx_r <= pidx_r + SW'(1);
      end
      if (cmd.first_set) begin
        if (!sym_ok || cnt_rd_r == 17'd0 || first_hi < off_rd_r) begin
          empty_r <= 1'b1; lo_r <= '0; hi_r <= '0;
        end else begin
          empty_r <= 1'b0; lo_r <= off_rd_r; hi_r <= first_hi;
        end
      end
      if (cmd.scan_init) begin
        lo_ptr_r <= lo_r; hi_ptr_r <= hi_clip;
        scan_lo_b_r <= lo_r; scan_hi_b_r <= hi_clip;
      end
      if (cmd.scan_lo) lo_ptr_r <= lo_ptr_r + 17'd1;
      if (cmd.scan_hi) hi_ptr_r <= hi_ptr_r - 17'd1;
      if (sts.lo_hit) nlo_r <= cand;
      if (cmd.narrow_done) begin
        if (cand < nlo_r) begin
          empty_r <= 1'b1; lo_r <= '0; hi_r <= '0;
        end else begin
          lo_r <= nlo_r; hi_r <= cand;
        end
      end
      if (cmd.mark_empty) begin
        empty_r <= 1'b1; lo_r <= '0; hi_r <= '0;
      end
      if (cmd.query_set) active_r <= 1'b1;
      if (cmd.query_clr) active_r <= 1'b0;
    end
  end

  // status
  logic [16:0] lo_issued;
  assign lo_issued = lo_ptr_r - 17'd1;
  always_comb begin
    sts.pfx_last     = ({{(32-SW){1'b0}}, pidx_r} == ALPHABET - 1);
    sts.query_active = active_r;
    sts.intv_empty   = empty_r;
    sts.scan_skip    = !sym_ok || len_r == '0 || lo_r > hi_clip;
    sts.lo_hit       = hit;
    sts.lo_end       = lo_issued == scan_hi_b_r;
    sts.hi_hit       = hit;
    sts.clr_busy     = clr_r;
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load || cmd.out_query || cmd.out_read) begin
      res_found <= 1'b0; res_count <= '0; res_first <= '0;
      res_last <= '0; res_pos <= '0;
      res_kind <= cmd.out_load ? RES_LOAD : (cmd.out_query ? RES_QUERY : RES_READ);
      if (cmd.out_query && !empty_r) begin
        res_found <= 1'b1; res_count <= hi_r - lo_r + 17'd1;
        res_first <= lo_r[15:0]; res_last <= hi_r[15:0];
      end
      if (cmd.out_read && ({1'b0, ridx_r} < 17'(len_r)))
        res_pos <= rd_sa_r;
    end
  end
endmodule

// ===== hw/rtl/bwt_ctrl.sv =====
// Controller FSM: sequences loads, prefix sums, scans and results.
// Depends on bwt_pkg and the assertion macro header.
`include "bwt_backward_search_unit_assert.svh"
module bwt_ctrl import bwt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic       in_last_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output bwt_cmd_t   cmd,
  input  bwt_sts_t   sts
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_LOAD = 10'b0000000010, S_PFX = 10'b0000000100,
    S_PAT  = 10'b0000001000, S_SLO  = 10'b0000010000, S_SHI = 10'b0000100000,
    S_RD   = 10'b0001000000, S_RD2  = 10'b0010000000, S_FIN = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic last_r, last_nxt, ov_r, ov_nxt, lo_first_r, lo_first_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE) && !sts.clr_busy;
  assign out_valid = ov_r;
  // result register can take a new word this cycle
  assign out_free  = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r; last_nxt = last_r; kind_nxt = kind_r; ov_nxt = ov_r;
    lo_first_nxt = lo_first_r;
    cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1; last_nxt = in_last_symbol; kind_nxt = in_kind;
          unique case (kind_t'(in_kind))
            KIND_LOAD:    state_nxt = S_LOAD;
            KIND_FINISH:  begin cmd.pfx_clear = 1'b1; state_nxt = S_PFX; end
            KIND_PATTERN: state_nxt = S_PAT;
            KIND_READ:    state_nxt = S_RD;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin cmd.load_wr = 1'b1; state_nxt = S_IDLE; end
      S_PFX: begin
        cmd.pfx_step = 1'b1;
        if (sts.pfx_last) state_nxt = S_OUT;
      end
      S_PAT: begin
        if (!sts.query_active) begin
          cmd.first_set = 1'b1; state_nxt = S_FIN;
        end else if (sts.intv_empty) begin
          state_nxt = S_FIN;
        end else if (sts.scan_skip) begin
          cmd.mark_empty = 1'b1; state_nxt = S_FIN;
        end else begin
          cmd.scan_init = 1'b1; lo_first_nxt = 1'b1; state_nxt = S_SLO;
        end
      end
      S_SLO: begin
        // issue next read unless current result settles the low end
        lo_first_nxt = 1'b0;
        if (!lo_first_r && sts.lo_hit) begin
          lo_first_nxt = 1'b1; state_nxt = S_SHI;
        end else if (!lo_first_r && sts.lo_end) begin
          cmd.mark_empty = 1'b1; state_nxt = S_FIN;
        end else begin
          cmd.scan_lo = 1'b1;
        end
      end
      S_SHI: begin
        lo_first_nxt = 1'b0;
        if (!lo_first_r && sts.hi_hit) begin
          cmd.narrow_done = 1'b1; state_nxt = S_FIN;
        end else begin
          cmd.scan_hi = 1'b1;
        end
      end
      S_RD:  state_nxt = S_RD2;
      S_RD2: begin
        if (out_free) begin
          cmd.out_read = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (last_r) begin
          // hold until the result register frees up
          if (out_free) begin
            cmd.query_clr = 1'b1; cmd.out_query = 1'b1; ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.query_set = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.query_clr = 1'b1; cmd.out_load = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; last_r <= 1'b0; kind_r <= '0;
      lo_first_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; last_r <= last_nxt; kind_r <= kind_nxt;
      lo_first_r <= lo_first_nxt;
    end
  end

  `BSU_ASSERT_IMP(a_busy_no_accept, state_r != S_IDLE, !in_ready)
  `BSU_ASSERT_NXT(a_pfx_result, state_r == S_OUT && out_free, out_valid)
  `BSU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BSU_ASSERT_IMP(a_kind_used, state_r == S_LOAD, kind_r == KIND_LOAD)
endmodule

// ===== hw/rtl/bwt_backward_search_unit.sv =====
// Top level of the FM-index backward search unit.
// Depends on bwt_pkg, bwt_ctrl and bwt_datapath.
//
//  channel | ports                                   | role
//  in      | in_valid/in_ready, in_kind..last_symbol | load, finish, pattern, read words
//  out     | out_valid/out_ready, out_result_kind..  | load done, query answer, position
//
// A load word is latched, then written. A finish word walks the prefix adder,
// one offset entry per cycle, then gives the result. A pattern byte needs no
// scan for the first byte or an empty interval; otherwise the rows are scanned
// from each end of the interval, one memory read per cycle.
// Reset clears length and query state and starts a clearing pass over the
// count and offset tables; input waits until it ends.
// A pending result holds only the next result-producing step; loads still pass.
module bwt_backward_search_unit import bwt_pkg::*; #(
  parameter int unsigned MAX_LEN  = MaxLenDef,
  parameter int unsigned ALPHABET = AlphabetDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_sa_value,
  input  logic [15:0] in_read_index,
  input  logic        in_last_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic        out_found,
  output logic [16:0] out_match_count,
  output logic [15:0] out_range_first,
  output logic [15:0] out_range_last,
  output logic [15:0] out_text_position
);
  bwt_cmd_t cmd;
  bwt_sts_t sts;

  bwt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_last_symbol,
    .out_valid, .out_ready, .cmd, .sts
  );

  bwt_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_symbol, .in_sa_value, .in_read_index,
    .res_kind(out_result_kind), .res_found(out_found), .res_count(out_match_count),
    .res_first(out_range_first), .res_last(out_range_last), .res_pos(out_text_position)
  );
endmodule

// ===== tb/sv/bwt_backward_search_unit_test.sv =====
// Self-checking testbench for bwt_backward_search_unit: random and directed words
// are checked against a built-in backward search predictor. Depends on bwt_pkg.
module bwt_backward_search_unit_test;
  import bwt_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  symbol;
    logic [15:0] sa_value;
    logic [15:0] read_index;
    logic        last_symbol;
  } in_word_t;

  typedef struct {
    res_kind_t   kind;
    logic        found;
    logic [16:0] count;
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] position;
  } answer_t;

  localparam int unsigned CycleLimit = 16000000;
  localparam int unsigned DrainCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_symbol = '0;
  logic [15:0] in_sa_value = '0;
  logic [15:0] in_read_index = '0;
  logic        in_last_symbol = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic        out_found;
  logic [16:0] out_match_count;
  logic [15:0] out_range_first;
  logic [15:0] out_range_last;
  logic [15:0] out_text_position;

  bwt_backward_search_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // search state mirrored from the block
  logic [7:0]  bwt_mem [65536];
  logic [15:0] sa_mem [65536];
  logic [16:0] rank_mem [65536];
  logic [16:0] sym_count [256];
  logic [16:0] sym_offset [256];
  int unsigned text_len;
  logic [16:0] lo_row, hi_row;
  logic        in_query, no_match;

  in_word_t    word_q[$];
  answer_t     answer_q[$];
  in_word_t    held;
  int unsigned words_taken;
  int unsigned errors;
  int unsigned gen_len;

  function automatic void clear_interval();
    no_match = 1'b1;
    lo_row = '0;
    hi_row = '0;
  endfunction

  function automatic void narrow_interval(logic [7:0] s);
    int unsigned lo, hi, i, nlo, nhi;
    bit hit;
    lo = lo_row;
    hi = hi_row;
    hit = 0;
    nlo = 0;
    nhi = 0;
    if (text_len == 0) begin
      clear_interval();
      return;
    end
    if (hi >= text_len) hi = text_len - 1;
    if (lo > hi) begin
      clear_interval();
      return;
    end
    for (i = lo; i <= hi; i++) begin
      if (bwt_mem[i] == s) begin
        nlo = sym_offset[s] + rank_mem[i];
        hit = 1;
        break;
      end
    end
    if (!hit) begin
      clear_interval();
      return;
    end
    for (i = hi; ; i--) begin
      if (bwt_mem[i] == s) begin
        nhi = sym_offset[s] + rank_mem[i];
        break;
      end
      if (i == lo) break;
    end
    lo_row = nlo[16:0];
    hi_row = nhi[16:0];
    if (hi_row < lo_row) clear_interval();
  endfunction

  function automatic void search_step(in_word_t w);
    answer_t a;
    a = '{RES_LOAD, 1'b0, '0, '0, '0, '0};
    case (w.kind)
      KIND_LOAD: begin
        if (text_len < 65536) begin
          bwt_mem[text_len] = w.symbol;
          sa_mem[text_len] = w.sa_value;
          rank_mem[text_len] = sym_count[w.symbol];
          sym_count[w.symbol] = sym_count[w.symbol] + 17'd1;
          text_len++;
        end
      end
      KIND_FINISH: begin
        sym_offset[0] = '0;
        for (int k = 1; k < 256; k++) sym_offset[k] = sym_offset[k-1] + sym_count[k-1];
        in_query = 1'b0;
        answer_q.push_back(a);
      end
      KIND_PATTERN: begin
        if (!in_query) begin
          if (sym_count[w.symbol] == 0) begin
            clear_interval();
          end else begin
            lo_row = sym_offset[w.symbol];
            hi_row = sym_offset[w.symbol] + sym_count[w.symbol] - 17'd1;
            no_match = hi_row < lo_row;
            if (no_match) clear_interval();
          end
        end else if (!no_match) begin
          narrow_interval(w.symbol);
        end
        if (!w.last_symbol) begin
          in_query = 1'b1;
        end else begin
          in_query = 1'b0;
          a.kind = RES_QUERY;
          if (!no_match) begin
            a.found = 1'b1;
            a.count = hi_row - lo_row + 17'd1;
            a.first = lo_row[15:0];
            a.last = hi_row[15:0];
          end
          answer_q.push_back(a);
        end
      end
      default: begin
        a.kind = RES_READ;
        if (w.read_index < text_len) a.position = sa_mem[w.read_index];
        answer_q.push_back(a);
      end
    endcase
  endfunction

  function automatic void add_word(kind_t k, logic [7:0] s, logic [15:0] sa,
                                   logic [15:0] idx, logic last);
    word_q.push_back('{k, s, sa, idx, last});
    if (k == KIND_LOAD) gen_len++;
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(4) == 0) return 8'($urandom);
    return 8'h41 + 8'($urandom_range(3));
  endfunction

  // idle and stall percentages per phase of the run
  function automatic int unsigned send_idle();
    case ((words_taken / 150) % 4)
      1: return 63;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall();
    case ((words_taken / 150) % 4)
      2: return 63;
      3: return 17;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        search_step(held);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle()) begin
          held = word_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= held.kind;
          in_symbol <= held.symbol;
          in_sa_value <= held.sa_value;
          in_read_index <= held.read_index;
          in_last_symbol <= held.last_symbol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result word kind=%0d", $time, out_result_kind);
          errors++;
        end else begin
          e = answer_q.pop_front();
          if (out_result_kind !== e.kind || out_found !== e.found ||
              out_match_count !== e.count || out_range_first !== e.first ||
              out_range_last !== e.last || out_text_position !== e.position) begin
            $display("%0t: mismatch expected kind=%0d found=%0d count=%0d first=%0d last=%0d pos=%0d",
                     $time, e.kind, e.found, e.count, e.first, e.last, e.position);
            $display("%0t:          actual kind=%0d found=%0d count=%0d first=%0d last=%0d pos=%0d",
                     $time, out_result_kind, out_found, out_match_count, out_range_first,
                     out_range_last, out_text_position);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall());
    end
  end

  int unsigned cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned n, r;
    for (int k = 0; k < 256; k++) begin
      sym_count[k] = '0;
      sym_offset[k] = '0;
    end
    text_len = 0;
    lo_row = '0;
    hi_row = '0;
    in_query = 1'b0;
    no_match = 1'b0;

    // directed: empty store, byte extremes, single and multi byte queries
    add_word(KIND_READ, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_PATTERN, 8'h41, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_LOAD, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_word(KIND_LOAD, 8'h41, 16'h1234, 16'h0000, 1'b0);
    add_word(KIND_LOAD, 8'h42, 16'h0003, 16'h0000, 1'b0);
    add_word(KIND_LOAD, 8'h41, 16'h0004, 16'h0000, 1'b0);
    add_word(KIND_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_PATTERN, 8'h00, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_PATTERN, 8'hFF, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_PATTERN, 8'h41, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_READ, 8'h00, 16'h0000, 16'h0001, 1'b0);
    add_word(KIND_PATTERN, 8'h41, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_PATTERN, 8'h42, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_PATTERN, 8'h77, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_PATTERN, 8'h41, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_PATTERN, 8'h41, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_LOAD, 8'h42, 16'hABCD, 16'h0000, 1'b0);
    add_word(KIND_PATTERN, 8'h42, 16'h0000, 16'h0000, 1'b1);
    add_word(KIND_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_FINISH, 8'h00, 16'h0000, 16'h0000, 1'b0);
    add_word(KIND_READ, 8'h00, 16'h0000, 16'hFFFF, 1'b0);
    add_word(KIND_READ, 8'h00, 16'h0000, 16'h0005, 1'b0);

    while (word_q.size() < 1050) begin
      r = $urandom_range(99);
      if (r < 20 && gen_len < 1500) begin
        n = $urandom_range(1, 24);
        repeat (n) add_word(KIND_LOAD, pick_symbol(), 16'($urandom), 16'($urandom), 1'($urandom));
        if ($urandom_range(9) < 8) add_word(KIND_FINISH, 8'($urandom), 16'($urandom),
                                            16'($urandom), 1'($urandom));
      end else if (r < 75) begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          add_word(KIND_PATTERN, pick_symbol(), 16'($urandom), 16'($urandom), 1'b0);
          if ($urandom_range(19) == 0)
            add_word(KIND_READ, 8'($urandom), 16'($urandom),
                     16'($urandom_range(gen_len)), 1'($urandom));
        end
        // drop the query now and then with a finish instead of its closing byte
        if ($urandom_range(29) == 0)
          add_word(KIND_FINISH, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        else
          add_word(KIND_PATTERN, pick_symbol(), 16'($urandom), 16'($urandom), 1'b1);
      end else if (r < 90) begin
        add_word(KIND_READ, 8'($urandom), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(gen_len)),
                 1'($urandom));
      end else begin
        add_word(kind_t'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (word_q.size() == 0 && !in_valid);
    wait (answer_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
